FILE: design/tnet_pkg.sv
// Package for the timed note event table: operation codes, slot geometry,
// slot entry layout and the slot index wrap helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tnet_pkg;

    // Slot table geometry
    localparam int SLOT_COUNT  = 16;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);

    // Operation codes carried on the kind field
    typedef enum logic [1:0] {
        KIND_SCHEDULE = 2'd0,
        KIND_CANCEL   = 2'd1,
        KIND_TICK     = 2'd2,
        KIND_CLEAR    = 2'd3
    } t_kind;

    // One stored event
    typedef struct packed {
        logic [31:0] due_time;
        logic [6:0]  note;
        logic        is_on;
    } t_slot_entry;

    localparam int ENTRY_W = $bits(t_slot_entry);

    // Round-robin successor of a slot index
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] idx);
        next_slot = (idx == SLOT_W'(SLOT_COUNT - 1)) ? '0 : idx + SLOT_W'(1);
    endfunction

endpackage

`default_nettype wire

FILE: design/timed_note_event_table_unit.sv
// Timed note event table: top level with slot sequencer, valid bits and output register.
// Depends on tnet_pkg and tnet_ram.
`timescale 1ns / 1ps
`default_nettype none

// Channel    | Direction | Handshake           | Payload
// -----------+-----------+---------------------+------------------------------------------
// command    | in        | i_valid / o_ready   | i_kind, i_time_ms, i_note, i_note_on
// event      | out       | o_valid / i_ready   | o_note_value, o_key_down, o_end_of_run
//
// Sequencing: one transaction is taken in IDLE. Clear finishes in that same cycle.
// Schedule walks the valid bits from the cursor, one slot a cycle, and flushes the
// event straight out when the table is full. Cancel and tick walk all slots: a free
// slot is passed over, a valid one is read from the RAM, then compared; a tick
// ends with a flush when it fires. The single registered-read slot RAM and the
// shared time/note comparator set this pace.
// Reset (synchronous, active low) empties the table, zeroes the cursor and drops
// any result held. A stalled event channel stalls the sequencer whenever an event
// needs the output register while it still holds an unaccepted result: a later fired event
// of a tick, or the last event of a run in the flush cycle.

module timed_note_event_table_unit
    import tnet_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [31:0] i_time_ms,
    input  wire logic [6:0]  i_note,
    input  wire logic        i_note_on,
    // event channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [6:0]  o_note_value,
    output logic             o_key_down,
    output logic             o_end_of_run
);

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SEEK  = 5'b00010,   // schedule: look for a free slot
        S_READ  = 5'b00100,   // cancel/tick: fetch a valid slot
        S_CHECK = 5'b01000,   // cancel/tick: compare fetched slot
        S_FLUSH = 5'b10000    // send the held result as the last of the run
    } t_state;

    t_state                r_state, n_state;
    t_kind                 r_op, n_op;
    logic [31:0]           r_time, n_time;
    logic [6:0]            r_note, n_note;
    logic                  r_on, n_on;
    logic [SLOT_W-1:0]     r_idx, n_idx;
    logic [SLOT_W-1:0]     r_steps, n_steps;
    logic [SLOT_W-1:0]     r_cursor, n_cursor;
    logic [SLOT_COUNT-1:0] r_valid, n_valid;
    logic [FIRE_W-1:0]     r_fired, n_fired;
    // one fired event is held back until we know whether another follows
    logic                  r_pend_valid, n_pend_valid;
    logic [6:0]            r_pend_note, n_pend_note;
    logic                  r_pend_on, n_pend_on;
    // output register
    logic                  r_o_valid, n_o_valid;
    logic [6:0]            r_o_note;
    logic                  r_o_on;
    logic                  r_o_eor;

    logic                  out_load;
    logic [6:0]            out_note;
    logic                  out_on;
    logic                  out_eor;
    logic                  out_free;
    logic                  scan_last;
    logic                  slot_due;
    logic                  slot_match;
    logic                  fire_room;

    logic                  ram_we;
    logic                  ram_re;
    t_slot_entry           ram_wdata;
    t_slot_entry           ram_rdata;

    tnet_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign ram_wdata = '{due_time: r_time, note: r_note, is_on: r_on};

    // The shared compare unit: due time for tick, note and flag for cancel
    assign slot_due   = (r_time >= ram_rdata.due_time);
    assign slot_match = (ram_rdata.note == r_note) && (ram_rdata.is_on == r_on);
    assign scan_last  = (r_idx == SLOT_W'(SLOT_COUNT - 1));
    assign fire_room  = (r_fired != FIRE_W'(MAX_RESULTS));
    assign out_free   = !r_o_valid || i_ready;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_time       = r_time;
        n_note       = r_note;
        n_on         = r_on;
        n_idx        = r_idx;
        n_steps      = r_steps;
        n_cursor     = r_cursor;
        n_valid      = r_valid;
        n_fired      = r_fired;
        n_pend_valid = r_pend_valid;
        n_pend_note  = r_pend_note;
        n_pend_on    = r_pend_on;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        out_load     = 1'b0;
        out_note     = r_pend_note;
        out_on       = r_pend_on;
        out_eor      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    // capture the transaction
                    n_op    = t_kind'(i_kind);
                    n_time  = i_time_ms;
                    n_note  = i_note;
                    n_on    = i_note_on;
                    n_steps = '0;
                    n_fired = '0;
                    n_idx   = '0;
                    unique case (t_kind'(i_kind))
                        KIND_SCHEDULE: begin
                            n_idx   = r_cursor;
                            n_state = S_SEEK;
                        end
                        KIND_CANCEL, KIND_TICK: begin
                            n_state = S_READ;
                        end
                        KIND_CLEAR: begin
                            // cursor keeps its value
                            n_valid = '0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_SEEK: begin
                if (!r_valid[r_idx]) begin
                    ram_we           = 1'b1;
                    n_valid[r_idx]   = 1'b1;
                    n_cursor         = next_slot(r_idx);
                    n_state          = S_IDLE;
                end else if (r_steps == SLOT_W'(SLOT_COUNT - 1)) begin
                    // table full: bounce the event straight out
                    n_pend_valid = 1'b1;
                    n_pend_note  = r_note;
                    n_pend_on    = r_on;
                    n_state      = S_FLUSH;
                end else begin
                    n_idx   = next_slot(r_idx);
                    n_steps = r_steps + SLOT_W'(1);
                end
            end

            S_READ: begin
                if (r_valid[r_idx] && !(r_op == KIND_TICK && !fire_room)) begin
                    ram_re  = 1'b1;
                    n_state = S_CHECK;
                end else if (scan_last) begin
                    n_state = r_pend_valid ? S_FLUSH : S_IDLE;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end

            S_CHECK: begin
                if (r_op == KIND_TICK && slot_due && r_pend_valid && !out_free) begin
                    // hold: the earlier fired event still occupies the output
                    n_state = S_CHECK;
                end else begin
                    if (r_op == KIND_TICK && slot_due) begin
                        if (r_pend_valid) begin
                            out_load = 1'b1;
                        end
                        n_pend_valid   = 1'b1;
                        n_pend_note    = ram_rdata.note;
                        n_pend_on      = ram_rdata.is_on;
                        n_valid[r_idx] = 1'b0;
                        n_fired        = r_fired + FIRE_W'(1);
                    end else if (r_op == KIND_CANCEL && slot_match) begin
                        n_valid[r_idx] = 1'b0;
                    end
                    if (scan_last) begin
                        n_state = n_pend_valid ? S_FLUSH : S_IDLE;
                    end else begin
                        n_idx   = r_idx + SLOT_W'(1);
                        n_state = S_READ;
                    end
                end
            end

            S_FLUSH: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    out_eor      = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_o_valid = out_load || (r_o_valid && !i_ready);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cursor     <= '0;
            r_valid      <= '0;
            r_fired      <= '0;
            r_pend_valid <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cursor     <= n_cursor;
            r_valid      <= n_valid;
            r_fired      <= n_fired;
            r_pend_valid <= n_pend_valid;
            r_o_valid    <= n_o_valid;
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_time      <= n_time;
        r_note      <= n_note;
        r_on        <= n_on;
        r_idx       <= n_idx;
        r_steps     <= n_steps;
        r_pend_note <= n_pend_note;
        r_pend_on   <= n_pend_on;
        if (out_load) begin
            r_o_note <= out_note;
            r_o_on   <= out_on;
            r_o_eor  <= out_eor;
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_note_value = r_o_note;
    assign o_key_down   = r_o_on;
    assign o_end_of_run = r_o_eor;

endmodule

`default_nettype wire

FILE: design/tnet_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tnet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data until the next read
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/tnet_checker.sv
// Port-level checker for the timed note event table, bound to the top level.
// Depends on tnet_pkg and timed_note_event_table_unit.
`timescale 1ns / 1ps
`default_nettype none

module tnet_checker
    import tnet_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic [1:0]  i_kind,
    input wire logic [31:0] i_time_ms,
    input wire logic [6:0]  i_note,
    input wire logic        i_note_on,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [6:0]  o_note_value,
    input wire logic        o_key_down,
    input wire logic        o_end_of_run
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_note_value)
            && $stable(o_key_down) && $stable(o_end_of_run))
        else $error("stalled result changed");

    // a waiting command holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_kind) && $stable(i_time_ms)
            && $stable(i_note) && $stable(i_note_on))
        else $error("waiting command changed");

    // an accepted transaction other than clear makes the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_kind != KIND_CLEAR) |=> !o_ready)
        else $error("ready straight after accept");

    // while idle, any result still waiting closes its run
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready && o_valid |-> o_end_of_run)
        else $error("idle with an unfinished run");

    // reset drops any held result and returns to idle
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("reset did not clear outputs");

endmodule

bind timed_note_event_table_unit tnet_checker u_tnet_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .i_kind       (i_kind),
    .i_time_ms    (i_time_ms),
    .i_note       (i_note),
    .i_note_on    (i_note_on),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_note_value (o_note_value),
    .o_key_down   (o_key_down),
    .o_end_of_run (o_end_of_run)
);

`default_nettype wire
